>>> rtl/core/gpfd_pkg.sv
// Shared types and constants for the gamepad poll frame decoder.
package gpfd_pkg;

	localparam int STORE_DEPTH = 9;
	localparam int POS_W       = 4;
	localparam int LEN_W       = 3;

	// Request codes on the input channel
	localparam logic CMD_OP_START = 1'b0;
	localparam logic CMD_OP_BYTE  = 1'b1;

	// Bytes sent to the pad
	localparam logic [7:0] TX_START    = 8'h01;
	localparam logic [7:0] TX_POLL     = 8'h42;
	localparam logic [7:0] TX_DATA_VIB = 8'h41;
	localparam logic [7:0] TX_DATA_OFF = 8'h00;
	localparam logic [7:0] TX_NONE     = 8'h00;

	localparam logic [7:0]  MARKER     = 8'h5A;
	localparam logic [15:0] BTN_MASK   = 16'hFFFF;
	localparam logic [7:0]  AXIS_BIAS  = 8'h80;
	localparam logic [7:0]  AXIS_TOP   = 8'd127;
	localparam logic [1:0]  LEN_MASK   = 2'b11;
	localparam logic [LEN_W-1:0] LEN_ANALOG = 3'd6;
	// Frame ends once position + 1 reaches length + 3
	localparam logic [POS_W:0] LEN_OFS = 5'd2;

	// Byte positions within the frame
	localparam logic [POS_W-1:0] POS_ID  = 4'd0;
	localparam logic [POS_W-1:0] POS_LEN = 4'd1;
	localparam logic [POS_W-1:0] POS_LAST = 4'd8;
	localparam int BYTE_MARKER = 2;
	localparam int BYTE_BTN_HI = 3;
	localparam int BYTE_BTN_LO = 4;
	localparam int BYTE_RX     = 5;
	localparam int BYTE_RY     = 6;
	localparam int BYTE_LX     = 7;
	localparam int BYTE_LY     = 8;

	// Registered input request
	typedef struct packed {
		logic       valid;
		logic       cmd;
		logic [7:0] rx_byte;
	} gpfd_item_t;

	typedef struct packed {
		logic [7:0]        tx_byte;
		logic              tx_valid;
		logic              frame_done;
		logic              frame_error;
		logic              analog_flag;
		logic [15:0]       buttons;
		logic signed [7:0] right_stick_x;
		logic signed [7:0] right_stick_y;
		logic signed [7:0] left_stick_x;
		logic signed [7:0] left_stick_y;
	} gpfd_res_t;

endpackage

>>> rtl/core/gpfd_if.sv
// Valid/ready channel interfaces for requests and results.
interface gpfd_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] rx_byte;

	modport source (output valid, output cmd, output rx_byte, input ready);
	modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

interface gpfd_out_if;
	logic              valid;
	logic              ready;
	logic [7:0]        tx_byte;
	logic              tx_valid;
	logic              frame_done;
	logic              frame_error;
	logic              analog_flag;
	logic [15:0]       buttons;
	logic signed [7:0] right_stick_x;
	logic signed [7:0] right_stick_y;
	logic signed [7:0] left_stick_x;
	logic signed [7:0] left_stick_y;

	modport source (output valid, output tx_byte, output tx_valid, output frame_done,
		output frame_error, output analog_flag, output buttons, output right_stick_x,
		output right_stick_y, output left_stick_x, output left_stick_y, input ready);
	modport sink (input valid, input tx_byte, input tx_valid, input frame_done,
		input frame_error, input analog_flag, input buttons, input right_stick_x,
		input right_stick_y, input left_stick_x, input left_stick_y, output ready);
endinterface

>>> rtl/core/gpfd_in_stage.sv
// Input register stage: captures one request per cycle unless it is full and not taken.
module gpfd_in_stage import gpfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid,
	output logic       ready,
	input  logic       cmd,
	input  logic [7:0] rx_byte,
	output gpfd_item_t item,
	input  logic       take
);

	logic       valid_s1;
	logic       cmd_s1;
	logic [7:0] rx_byte_s1;

	assign ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1     <= CMD_OP_START;
			rx_byte_s1 <= '0;
		end else if (ready && valid) begin
			cmd_s1     <= cmd;
			rx_byte_s1 <= rx_byte;
		end
	end

	assign item = '{valid: valid_s1, cmd: cmd_s1, rx_byte: rx_byte_s1};

endmodule

>>> rtl/core/gpfd_frame_core.sv
// Frame tracking, decode and result register.
module gpfd_frame_core import gpfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  gpfd_item_t item,
	output logic       take,
	output logic       res_valid,
	input  logic       res_ready,
	output gpfd_res_t  res
);

	logic             vib_q;
	logic [7:0]       store_q [STORE_DEPTH];
	logic [7:0]       store_nx [STORE_DEPTH];
	logic [POS_W-1:0] pos_q, pos_nx;
	logic [LEN_W-1:0] len_q, len_nx;
	logic             active_q, active_nx;
	logic             res_valid_q;
	gpfd_res_t        res_q, res_nx;

	// Advance when the result register is free or being drained
	assign take = item.valid && (!res_valid_q || res_ready);

	always_comb begin
		store_nx  = store_q;
		pos_nx    = pos_q;
		len_nx    = len_q;
		active_nx = active_q;
		res_nx    = res_q;
		res_nx.tx_byte    = TX_NONE;
		res_nx.tx_valid   = 1'b0;
		res_nx.frame_done = 1'b0;
		unique case (item.cmd)
			CMD_OP_START: begin
				for (int i = 0; i < STORE_DEPTH; i++) begin
					store_nx[i] = '0;
				end
				pos_nx          = POS_ID;
				len_nx          = '0;
				active_nx       = 1'b1;
				res_nx.tx_byte  = TX_START;
				res_nx.tx_valid = 1'b1;
			end
			CMD_OP_BYTE: begin
				if (active_q) begin
					if (pos_q <= POS_LAST) begin
						store_nx[pos_q] = item.rx_byte;
					end
					if (pos_q == POS_LEN) begin
						len_nx = {item.rx_byte[1:0] & LEN_MASK, 1'b0};
					end
					if (pos_q != POS_ID && {1'b0, pos_q} >= {2'b00, len_nx} + LEN_OFS) begin
						active_nx         = 1'b0;
						pos_nx            = POS_ID;
						res_nx.frame_done = 1'b1;
						if (store_nx[BYTE_MARKER] == MARKER) begin
							res_nx.frame_error = 1'b0;
							res_nx.buttons =
								{store_nx[BYTE_BTN_HI], store_nx[BYTE_BTN_LO]} ^ BTN_MASK;
							if (len_nx == LEN_ANALOG) begin
								res_nx.analog_flag   = 1'b1;
								res_nx.right_stick_x = store_nx[BYTE_RX] ^ AXIS_BIAS;
								res_nx.right_stick_y = AXIS_TOP - store_nx[BYTE_RY];
								res_nx.left_stick_x  = store_nx[BYTE_LX] ^ AXIS_BIAS;
								res_nx.left_stick_y  = AXIS_TOP - store_nx[BYTE_LY];
							end else begin
								res_nx.analog_flag   = 1'b0;
								res_nx.right_stick_x = '0;
								res_nx.right_stick_y = '0;
								res_nx.left_stick_x  = '0;
								res_nx.left_stick_y  = '0;
							end
						end else begin
							res_nx.frame_error   = 1'b1;
							res_nx.analog_flag   = 1'b0;
							res_nx.buttons       = '0;
							res_nx.right_stick_x = '0;
							res_nx.right_stick_y = '0;
							res_nx.left_stick_x  = '0;
							res_nx.left_stick_y  = '0;
						end
					end else begin
						pos_nx          = pos_q + 1'b1;
						res_nx.tx_valid = 1'b1;
						if (pos_q == POS_ID) begin
							res_nx.tx_byte = TX_POLL;
						end else begin
							res_nx.tx_byte = vib_q ? TX_DATA_VIB : TX_DATA_OFF;
						end
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vib_q <= 1'b0;
		end else if (cfg_wr_en) begin
			vib_q <= cfg_wr_data;
		end
	end

	// Held decode fields live in the result register itself
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORE_DEPTH; i++) begin
				store_q[i] <= '0;
			end
			pos_q       <= POS_ID;
			len_q       <= '0;
			active_q    <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (take) begin
				store_q  <= store_nx;
				pos_q    <= pos_nx;
				len_q    <= len_nx;
				active_q <= active_nx;
				res_q    <= res_nx;
			end
			if (take) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_done_no_tx: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(res_q.frame_done && res_q.tx_valid))
		else $error("frame_done and tx_valid both set");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_LAST)
		else $error("byte position beyond frame");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_q.frame_error |-> (res_q.buttons == '0 && !res_q.analog_flag))
		else $error("error frame with nonzero decode");

	a_start_opens: assert property (@(posedge clk) disable iff (!arst_n)
		(take && item.cmd == CMD_OP_START) |=> (active_q && pos_q == POS_ID))
		else $error("start request did not open a frame");

endmodule

>>> rtl/core/gamepad_poll_frame_decoder_top.sv
// Gamepad poll frame decoder: top level.
//
// rx_chan carries requests: cmd = start opens a frame, cmd = byte delivers one
// byte received from the pad. res_chan returns exactly one result per request:
// the next byte to send (tx_byte / tx_valid), frame_done on the closing byte,
// and the held decode of the last completed frame (error flag, analog flag,
// buttons and four stick axes).
// vibrate_enable is written through cfg_wr_en / cfg_wr_data; write it only
// while no request is in flight.
// A request passes through the input register and then the result register.
// Throughput: one request per cycle unless res_chan stalls; both registers
// advance together.
// Reset clears the frame store, the byte position, the held decode and the
// vibrate bit; no frame is open until a start request arrives.
// When res_chan stalls, the result register holds, the input register fills,
// and rx_chan.ready drops once both are occupied; nothing is lost.
module gamepad_poll_frame_decoder_top import gpfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	gpfd_in_if.sink    rx_chan,
	gpfd_out_if.source res_chan
);

	gpfd_item_t item;
	gpfd_res_t  res;
	logic       take;

	gpfd_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid   (rx_chan.valid),
		.ready   (rx_chan.ready),
		.cmd     (rx_chan.cmd),
		.rx_byte (rx_chan.rx_byte),
		.item    (item),
		.take    (take)
	);

	gpfd_frame_core u_frame_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.item        (item),
		.take        (take),
		.res_valid   (res_chan.valid),
		.res_ready   (res_chan.ready),
		.res         (res)
	);

	assign res_chan.tx_byte       = res.tx_byte;
	assign res_chan.tx_valid      = res.tx_valid;
	assign res_chan.frame_done    = res.frame_done;
	assign res_chan.frame_error   = res.frame_error;
	assign res_chan.analog_flag   = res.analog_flag;
	assign res_chan.buttons       = res.buttons;
	assign res_chan.right_stick_x = res.right_stick_x;
	assign res_chan.right_stick_y = res.right_stick_y;
	assign res_chan.left_stick_x  = res.left_stick_x;
	assign res_chan.left_stick_y  = res.left_stick_y;

endmodule

>>> tb/gamepad_poll_frame_decoder_top_tb.sv
// Self-checking testbench for the gamepad poll frame decoder top level.
`timescale 1ns / 100ps

module gamepad_poll_frame_decoder_top_tb;
	import gpfd_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_wr_data;

	gpfd_in_if  in_if();
	gpfd_out_if out_if();

	gamepad_poll_frame_decoder_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.rx_chan    (in_if),
		.res_chan   (out_if)
	);

	// Frame decode model state
	logic [7:0]  frame_bytes [STORE_DEPTH];
	logic [3:0]  byte_pos;
	logic [2:0]  data_len;
	logic        frame_open;
	logic [15:0] held_btn;
	logic [7:0]  held_axis [4];
	logic        held_err;
	logic        held_analog;
	logic        model_vibrate;

	gpfd_res_t expected_replies [$];
	int        mismatches;
	int        requests_sent;
	int        send_idle_pct;
	int        recv_stall_pct;
	int        hold_left;

	always #4 clk = ~clk;

	function automatic gpfd_res_t predict_reply(input logic c, input logic [7:0] data);
		gpfd_res_t r;
		int p;
		r = '0;
		if (c == CMD_OP_START) begin
			for (int k = 0; k < STORE_DEPTH; k++) frame_bytes[k] = 8'h00;
			byte_pos = '0;
			data_len = '0;
			frame_open = 1'b1;
			r.tx_byte = TX_START;
			r.tx_valid = 1'b1;
		end else if (frame_open) begin
			p = int'(byte_pos);
			if (p < STORE_DEPTH) frame_bytes[p] = data;
			if (p == int'(POS_LEN)) data_len = {data[1:0], 1'b0};
			if (p >= 1 && p + 1 >= int'(data_len) + 3) begin
				// Decode the completed frame and hold it until the next one
				if (frame_bytes[2] == MARKER) begin
					held_btn = {frame_bytes[3], frame_bytes[4]} ^ 16'hFFFF;
					held_err = 1'b0;
					held_analog = (data_len >= 3'd6);
					if (held_analog) begin
						held_axis[0] = frame_bytes[5] ^ 8'h80;
						held_axis[1] = 8'd127 - frame_bytes[6];
						held_axis[2] = frame_bytes[7] ^ 8'h80;
						held_axis[3] = 8'd127 - frame_bytes[8];
					end else begin
						for (int k = 0; k < 4; k++) held_axis[k] = 8'h00;
					end
				end else begin
					held_btn = 16'h0000;
					held_err = 1'b1;
					held_analog = 1'b0;
					for (int k = 0; k < 4; k++) held_axis[k] = 8'h00;
				end
				frame_open = 1'b0;
				byte_pos = '0;
				r.frame_done = 1'b1;
			end else begin
				byte_pos = byte_pos + 4'd1;
				if (p == int'(POS_ID)) r.tx_byte = TX_POLL;
				else r.tx_byte = model_vibrate ? TX_DATA_VIB : TX_DATA_OFF;
				r.tx_valid = 1'b1;
			end
		end
		r.frame_error = held_err;
		r.analog_flag = held_analog;
		r.buttons = held_btn;
		r.right_stick_x = held_axis[0];
		r.right_stick_y = held_axis[1];
		r.left_stick_x = held_axis[2];
		r.left_stick_y = held_axis[3];
		return r;
	endfunction

	task automatic report(input string what, input logic [15:0] want, input logic [15:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: expected %h, got %h", $realtime, what, want, got);
	endtask

	task automatic check_reply();
		gpfd_res_t want;
		gpfd_res_t got;
		got.tx_byte = out_if.tx_byte;
		got.tx_valid = out_if.tx_valid;
		got.frame_done = out_if.frame_done;
		got.frame_error = out_if.frame_error;
		got.analog_flag = out_if.analog_flag;
		got.buttons = out_if.buttons;
		got.right_stick_x = out_if.right_stick_x;
		got.right_stick_y = out_if.right_stick_y;
		got.left_stick_x = out_if.left_stick_x;
		got.left_stick_y = out_if.left_stick_y;
		if (expected_replies.size() == 0) begin
			report("unexpected result, tx_byte", 16'h0, 16'(got.tx_byte));
		end else begin
			want = expected_replies.pop_front();
			if (got.tx_byte !== want.tx_byte)
				report("tx_byte", 16'(want.tx_byte), 16'(got.tx_byte));
			if (got.tx_valid !== want.tx_valid)
				report("tx_valid", 16'(want.tx_valid), 16'(got.tx_valid));
			if (got.frame_done !== want.frame_done)
				report("frame_done", 16'(want.frame_done), 16'(got.frame_done));
			if (got.frame_error !== want.frame_error)
				report("frame_error", 16'(want.frame_error), 16'(got.frame_error));
			if (got.analog_flag !== want.analog_flag)
				report("analog_flag", 16'(want.analog_flag), 16'(got.analog_flag));
			if (got.buttons !== want.buttons) report("buttons", want.buttons, got.buttons);
			if (got.right_stick_x !== want.right_stick_x)
				report("right_stick_x", 16'(want.right_stick_x), 16'(got.right_stick_x));
			if (got.right_stick_y !== want.right_stick_y)
				report("right_stick_y", 16'(want.right_stick_y), 16'(got.right_stick_y));
			if (got.left_stick_x !== want.left_stick_x)
				report("left_stick_x", 16'(want.left_stick_x), 16'(got.left_stick_x));
			if (got.left_stick_y !== want.left_stick_y)
				report("left_stick_y", 16'(want.left_stick_y), 16'(got.left_stick_y));
		end
	endtask

	// Predict on each accepted request, check each accepted result
	always @(posedge clk) begin
		if (in_if.valid === 1'b1 && in_if.ready === 1'b1)
			expected_replies.push_back(predict_reply(in_if.cmd, in_if.rx_byte));
		if (out_if.valid === 1'b1 && out_if.ready === 1'b1)
			check_reply();
	end

	// Result side: random stalls, plus a long hold-off when asked
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_if.ready = 1'b0;
			hold_left--;
		end else begin
			out_if.ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_request(input logic c, input logic [7:0] data);
		while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		in_if.cmd = c;
		in_if.rx_byte = data;
		in_if.valid = 1'b1;
		do @(posedge clk); while (in_if.ready !== 1'b1);
		@(negedge clk);
		in_if.valid = 1'b0;
		requests_sent++;
	endtask

	// Start request, then the given pad bytes
	task automatic send_frame(input logic [7:0] pad_bytes [$]);
		send_request(CMD_OP_START, 8'($urandom));
		foreach (pad_bytes[i]) send_request(CMD_OP_BYTE, pad_bytes[i]);
	endtask

	task automatic send_random_frame();
		logic [7:0] pad_bytes [$];
		logic [7:0] len_byte;
		int kind;
		int nbytes;
		kind = $urandom_range(99);
		if (kind < 6) begin
			// Stray byte, or a byte into a frame left open
			send_request(CMD_OP_BYTE, 8'($urandom));
		end else begin
			len_byte = 8'($urandom);
			nbytes = int'(len_byte[1:0]) * 2 + 3;
			// Truncate some frames so the next start drops them
			if (kind < 16) nbytes = $urandom_range(nbytes - 1);
			for (int i = 0; i < nbytes; i++) begin
				if (i == 1) pad_bytes.push_back(len_byte);
				else if (i == 2 && $urandom_range(99) < 85) pad_bytes.push_back(MARKER);
				else pad_bytes.push_back(8'($urandom));
			end
			send_frame(pad_bytes);
		end
	endtask

	task automatic wait_drained();
		while (expected_replies.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		@(posedge clk);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		@(negedge clk);
	endtask

	task automatic write_vibrate(input logic v);
		wait_drained();
		cfg_wr_en = 1'b1;
		cfg_wr_data = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		model_vibrate = v;
	endtask

	task automatic test_directed();
		// Byte with no open frame
		send_request(CMD_OP_BYTE, 8'hFF);
		// Analog frame with extreme button and axis values
		send_frame('{8'h73, 8'hFF, 8'h5A, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h7F});
		// Short digital frame
		send_frame('{8'h41, 8'h01, 8'h5A, 8'hFF, 8'h00});
		// Missing marker, zero length
		send_frame('{8'h00, 8'h00, 8'hA5});
		// Start during a frame: drop it and begin again
		send_request(CMD_OP_START, 8'h00);
		send_request(CMD_OP_BYTE, 8'h12);
		send_frame('{8'h79, 8'h02, 8'h5A, 8'h12, 8'h34, 8'h56, 8'h78});
		wait_drained();
	endtask

	task automatic test_random(input logic vib, input int send_pct, input int recv_pct,
			input int count);
		int target;
		write_vibrate(vib);
		set_idling(send_pct, recv_pct);
		target = requests_sent + count;
		while (requests_sent < target) send_random_frame();
		wait_drained();
	endtask

	task automatic test_backpressure();
		int target;
		set_idling(0, 0);
		@(posedge clk);
		hold_left = 300;
		@(negedge clk);
		target = requests_sent + 40;
		while (requests_sent < target) send_random_frame();
		// Pause until every result is back
		wait_drained();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b0;
		in_if.valid = 1'b0;
		in_if.cmd = CMD_OP_START;
		in_if.rx_byte = 8'h00;
		out_if.ready = 1'b0;
		for (int k = 0; k < STORE_DEPTH; k++) frame_bytes[k] = 8'h00;
		for (int k = 0; k < 4; k++) held_axis[k] = 8'h00;
		byte_pos = '0;
		data_len = '0;
		frame_open = 1'b0;
		held_btn = 16'h0000;
		held_err = 1'b0;
		held_analog = 1'b0;
		model_vibrate = 1'b0;
		mismatches = 0;
		requests_sent = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random(1'b1, 0, 0, 400);
		test_random(1'b0, 65, 0, 400);
		test_random(1'b1, 0, 65, 400);
		test_random(1'b0, 13, 13, 400);
		test_backpressure();
		wait_drained();

		if (mismatches == 0)
			$display("gamepad_poll_frame_decoder_top: match");
		else
			$display("gamepad_poll_frame_decoder_top: mismatch");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("gamepad_poll_frame_decoder_top: mismatch");
		$finish;
	end

endmodule
